### rtl/core/qlr_pkg.sv
// ----------------------------------------------------------------------------
// qlr_pkg
// Shared constants and codes for the Q14 linear resize pass.
// ----------------------------------------------------------------------------
`default_nettype none

package qlr_pkg;

  // Line store geometry
  localparam int ROW_DEPTH = 4096;
  localparam int ROW_AW    = (ROW_DEPTH > 1) ? $clog2(ROW_DEPTH) : 1;

  // Q14 arithmetic constants
  localparam logic [14:0] Q14_ONE   = 15'd16384;
  localparam logic [31:0] Q14_HALF  = 32'd8192;
  localparam logic [17:0] SIGN_BIAS = 18'd32768;

  // Item kinds
  typedef enum logic [1:0] {
    KIND_LOAD  = 2'd0,
    KIND_VERT  = 2'd1,
    KIND_HORZ  = 2'd2,
    KIND_UNUSED = 2'd3
  } kind_t;

  // Output formats
  typedef enum logic [1:0] {
    FMT_RAW = 2'd0,
    FMT_S16 = 2'd1,
    FMT_U16 = 2'd2,
    FMT_U8  = 2'd3
  } fmt_t;

  // Register indexes (word address on the configuration port)
  localparam logic REG_VWEIGHT = 1'b0;
  localparam logic REG_FORMAT  = 1'b1;

endpackage

`default_nettype wire

### rtl/core/q14_linear_resize_pass.sv
// ----------------------------------------------------------------------------
// q14_linear_resize_pass
// Two-tap Q14 linear resampler with a 16-bit line store and output formatting.
// ----------------------------------------------------------------------------
// Sequence: an accepted blend registers its taps and payload, then the product
//   in ST_MUL, then out_value and out_valid from ST_FMT; a load writes on accept.
// Throughput: one load per cycle while idle; a blend (line store read, multiply
//   stage, round/format stage) holds busy. The receiver cannot stall.
// Reset: synchronous active-low; clears control and the two registers. The line
//   store is not cleared: entries read before being written are undefined.
`default_nettype none

module q14_linear_resize_pass (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input channel
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_kind,
  input  wire logic [11:0] in_row_address,
  input  wire logic [15:0] in_upper_sample,
  input  wire logic [15:0] in_lower_sample,
  input  wire logic [11:0] in_left_index,
  input  wire logic [11:0] in_right_index,
  input  wire logic [14:0] in_pixel_weight,
  // result channel
  output logic             out_valid,
  output logic signed [16:0] out_value,
  // configuration port
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_FMT
  } state_t;

  state_t state_r;

  // Configuration registers
  logic [14:0]        vweight_r;
  qlr_pkg::fmt_t      fmt_r;

  // Line store
  logic [15:0] row_mem [qlr_pkg::ROW_DEPTH];
  logic [15:0] tap0_rd_r;
  logic [15:0] tap1_rd_r;
  logic        tap0_ok_r;
  logic        tap1_ok_r;

  // Captured transaction
  logic        horz_r;
  logic [15:0] s0_in_r;
  logic [15:0] s1_in_r;
  logic [14:0] pweight_r;

  // Multiply stage
  logic signed [31:0] prod_r;
  logic [15:0]        base_r;

  logic        out_valid_r;
  logic signed [16:0] out_value_r;

  logic        accept;
  logic        cfg_wr;
  logic [qlr_pkg::ROW_AW-1:0] wr_addr;
  logic [qlr_pkg::ROW_AW-1:0] rd0_addr;
  logic [qlr_pkg::ROW_AW-1:0] rd1_addr;
  logic        wr_ok;
  logic        rd0_ok;
  logic        rd1_ok;

  logic [15:0]        s0;
  logic [15:0]        s1;
  logic [14:0]        w_sel;
  logic [14:0]        w_clamp;
  logic signed [16:0] diff;
  logic signed [31:0] prod_nxt;

  logic signed [31:0] rounded;
  logic signed [17:0] q_shift;
  logic signed [17:0] blend_v;
  logic signed [17:0] biased;
  logic signed [16:0] out_value_nxt;

  assign accept    = start && !busy;
  assign busy      = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_value = out_value_r;
  assign pready    = 1'b1;
  assign cfg_wr    = psel && penable && pwrite && pready;

  // Configuration read mux
  always_comb begin
    if (paddr[2] == qlr_pkg::REG_FORMAT) begin
      prdata = {30'd0, fmt_r};
    end else begin
      prdata = {17'd0, vweight_r};
    end
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vweight_r <= '0;
      fmt_r     <= qlr_pkg::FMT_RAW;
    end else if (cfg_wr) begin
      if (paddr[2] == qlr_pkg::REG_VWEIGHT) begin
        vweight_r <= pwdata[14:0];
      end else begin
        fmt_r <= qlr_pkg::fmt_t'(pwdata[1:0]);
      end
    end
  end

  // Line store addressing; out-of-range taps read as zero
  assign wr_addr  = qlr_pkg::ROW_AW'(in_row_address);
  assign rd0_addr = qlr_pkg::ROW_AW'(in_left_index);
  assign rd1_addr = qlr_pkg::ROW_AW'(in_right_index);
  assign wr_ok    = (32'(in_row_address) < 32'(qlr_pkg::ROW_DEPTH));
  assign rd0_ok   = (32'(in_left_index)  < 32'(qlr_pkg::ROW_DEPTH));
  assign rd1_ok   = (32'(in_right_index) < 32'(qlr_pkg::ROW_DEPTH));

  // Line store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (accept && (qlr_pkg::kind_t'(in_kind) == qlr_pkg::KIND_LOAD) && wr_ok) begin
      row_mem[wr_addr] <= in_upper_sample;
    end
    tap0_rd_r <= row_mem[rd0_addr];
    tap1_rd_r <= row_mem[rd1_addr];
  end

  // Capture transaction payload
  always_ff @(posedge clk) begin
    if (accept) begin
      horz_r    <= (qlr_pkg::kind_t'(in_kind) == qlr_pkg::KIND_HORZ);
      s0_in_r   <= in_upper_sample;
      s1_in_r   <= in_lower_sample;
      pweight_r <= in_pixel_weight;
      tap0_ok_r <= rd0_ok;
      tap1_ok_r <= rd1_ok;
    end
  end

  // Tap and weight select, then multiply
  always_comb begin
    if (horz_r) begin
      s0    = tap0_ok_r ? tap0_rd_r : 16'd0;
      s1    = tap1_ok_r ? tap1_rd_r : 16'd0;
      w_sel = pweight_r;
    end else begin
      s0    = s0_in_r;
      s1    = s1_in_r;
      w_sel = vweight_r;
    end
    w_clamp  = (w_sel > qlr_pkg::Q14_ONE) ? qlr_pkg::Q14_ONE : w_sel;
    diff     = $signed({1'b0, s1}) - $signed({1'b0, s0});
    prod_nxt = 32'($signed({1'b0, w_clamp})) * 32'(diff);
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_MUL) begin
      prod_r <= prod_nxt;
      base_r <= s0;
    end
  end

  // Round, shift and format
  always_comb begin
    rounded = prod_r + $signed(qlr_pkg::Q14_HALF);
    q_shift = 18'(rounded >>> 14);
    blend_v = $signed({2'b00, base_r}) + q_shift;
    biased  = blend_v - $signed(qlr_pkg::SIGN_BIAS);
    case (fmt_r)
      qlr_pkg::FMT_RAW: begin
        out_value_nxt = blend_v[16:0];
      end
      qlr_pkg::FMT_S16: begin
        if (biased < -18'sd32768) begin
          out_value_nxt = -17'sd32768;
        end else if (biased > 18'sd32767) begin
          out_value_nxt = 17'sd32767;
        end else begin
          out_value_nxt = biased[16:0];
        end
      end
      qlr_pkg::FMT_U16: begin
        if (blend_v < 18'sd0) begin
          out_value_nxt = 17'sd0;
        end else if (blend_v > 18'sd65535) begin
          out_value_nxt = 17'sd65535;
        end else begin
          out_value_nxt = blend_v[16:0];
        end
      end
      qlr_pkg::FMT_U8: begin
        if (blend_v < 18'sd0) begin
          out_value_nxt = 17'sd0;
        end else if (blend_v > 18'sd255) begin
          out_value_nxt = 17'sd255;
        end else begin
          out_value_nxt = blend_v[16:0];
        end
      end
      default: begin
        out_value_nxt = blend_v[16:0];
      end
    endcase
  end

  // Sequencer and registered result
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= 1'b0;
      case (state_r)
        ST_IDLE: begin
          if (accept && ((qlr_pkg::kind_t'(in_kind) == qlr_pkg::KIND_VERT) ||
                         (qlr_pkg::kind_t'(in_kind) == qlr_pkg::KIND_HORZ))) begin
            state_r <= ST_MUL;
          end
        end
        ST_MUL: begin
          state_r <= ST_FMT;
        end
        ST_FMT: begin
          state_r     <= ST_IDLE;
          out_valid_r <= 1'b1;
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FMT) begin
      out_value_r <= out_value_nxt;
    end
  end

endmodule

`default_nettype wire

### tb/sv/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking testbench for the Q14 linear resize pass. Row loads, vertical
// and horizontal blends and ignored items are queued per register setting,
// driven in random bursts and checked against an in-bench blend predictor.
// ----------------------------------------------------------------------------

module tb;

  localparam int MAX_REPORTS = 10;

  // One input transaction as queued for the driver
  typedef struct {
    qlr_pkg::kind_t kind;
    logic [11:0] row_address;
    logic [15:0] upper_sample;
    logic [15:0] lower_sample;
    logic [11:0] left_index;
    logic [11:0] right_index;
    logic [14:0] pixel_weight;
    bit          wait_drained;  // hold off until all results are back
  } resize_item_t;

  // Clock, reset and DUT ports
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_kind = '0;
  logic [11:0]        in_row_address = '0;
  logic [15:0]        in_upper_sample = '0;
  logic [15:0]        in_lower_sample = '0;
  logic [11:0]        in_left_index = '0;
  logic [11:0]        in_right_index = '0;
  logic [14:0]        in_pixel_weight = '0;
  logic               out_valid;
  logic signed [16:0] out_value;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;

  // Predictor state: line store copy and register copies
  logic [15:0]        line_copy [qlr_pkg::ROW_DEPTH];
  logic [14:0]        vweight_copy = '0;
  qlr_pkg::fmt_t      format_copy = qlr_pkg::FMT_RAW;

  // Stimulus and scoreboard
  resize_item_t       pending_items [$];
  logic signed [16:0] expected_values [$];
  resize_item_t       active_item;
  bit                 holding = 1'b0;
  int                 burst_left = 0;
  int                 gap_left = 0;
  int                 error_count = 0;

  // Entries loaded so far, in stimulus order; only these are ever read back
  bit                 loaded_flag [qlr_pkg::ROW_DEPTH];
  int                 loaded_list [$];

  q14_linear_resize_pass dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_kind         (in_kind),
    .in_row_address  (in_row_address),
    .in_upper_sample (in_upper_sample),
    .in_lower_sample (in_lower_sample),
    .in_left_index   (in_left_index),
    .in_right_index  (in_right_index),
    .in_pixel_weight (in_pixel_weight),
    .out_valid       (out_valid),
    .out_value       (out_value),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk = ~clk;

  // Blend two taps with a Q14 weight, round, then apply the output format
  function automatic logic signed [16:0] resample_value(logic [15:0] s0, logic [15:0] s1,
                                                        logic [14:0] w_in,
                                                        qlr_pkg::fmt_t fmt);
    longint w;
    longint t;
    longint v;
    w = (w_in > qlr_pkg::Q14_ONE) ? longint'(qlr_pkg::Q14_ONE) : longint'(w_in);
    t = w * (longint'(s1) - longint'(s0)) + longint'(qlr_pkg::Q14_HALF);
    v = longint'(s0) + (t >>> 14);
    case (fmt)
      qlr_pkg::FMT_S16: begin
        v = v - longint'(qlr_pkg::SIGN_BIAS);
        if (v < -32768) v = -32768;
        if (v > 32767) v = 32767;
      end
      qlr_pkg::FMT_U16: begin
        if (v < 0) v = 0;
        if (v > 65535) v = 65535;
      end
      qlr_pkg::FMT_U8: begin
        if (v < 0) v = 0;
        if (v > 255) v = 255;
      end
      default: ;
    endcase
    return v[16:0];
  endfunction

  // Update the store copy or queue the expected result of an accepted item
  task automatic predict_accepted(resize_item_t it);
    case (it.kind)
      qlr_pkg::KIND_LOAD: line_copy[it.row_address] = it.upper_sample;
      qlr_pkg::KIND_VERT: expected_values.push_back(resample_value(it.upper_sample,
                                                                   it.lower_sample,
                                                                   vweight_copy,
                                                                   format_copy));
      qlr_pkg::KIND_HORZ: expected_values.push_back(resample_value(line_copy[it.left_index],
                                                                   line_copy[it.right_index],
                                                                   it.pixel_weight,
                                                                   format_copy));
      default: ;
    endcase
  endtask

  // Driver: bursts of transactions separated by random gaps
  always @(posedge clk) begin
    if (!rst_n) begin
      holding = 1'b0;
      burst_left = 0;
      gap_left = 0;
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        predict_accepted(active_item);
        holding = 1'b0;
      end
      if (!holding) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_items.size() > 0 &&
                     !(pending_items[0].wait_drained && expected_values.size() > 0)) begin
          active_item = pending_items.pop_front();
          holding = 1'b1;
          in_kind         <= active_item.kind;
          in_row_address  <= active_item.row_address;
          in_upper_sample <= active_item.upper_sample;
          in_lower_sample <= active_item.lower_sample;
          in_left_index   <= active_item.left_index;
          in_right_index  <= active_item.right_index;
          in_pixel_weight <= active_item.pixel_weight;
          if (burst_left > 0) burst_left--;
          if (burst_left == 0) begin
            // mix of short bursts, long unbroken stretches and idle gaps
            burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 80)
                                                     : $urandom_range(1, 16);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
          end
        end
      end
      start <= holding;
    end
  end

  // Monitor: compare each result strobe with the oldest expectation
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      if (expected_values.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: unexpected result out_value=%0d", out_value);
      end else if (out_value !== expected_values[0]) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("ERROR: out_value expected %0d, got %0d", expected_values[0], out_value);
        void'(expected_values.pop_front());
      end else begin
        void'(expected_values.pop_front());
      end
    end
  end

  // Register write over the APB-style port
  task automatic cfg_write(logic reg_index, logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_index, 2'b00};
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_index == qlr_pkg::REG_VWEIGHT) vweight_copy = data[14:0];
    else format_copy = qlr_pkg::fmt_t'(data[1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Block until every queued transaction is accepted and every result is back
  task automatic wait_drained();
    while (pending_items.size() != 0 || holding || expected_values.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  function automatic resize_item_t random_fields();
    resize_item_t it;
    it.kind         = qlr_pkg::kind_t'($urandom_range(0, 3));
    it.row_address  = 12'($urandom_range(0, 4095));
    it.upper_sample = 16'($urandom_range(0, 65535));
    it.lower_sample = 16'($urandom_range(0, 65535));
    it.left_index   = 12'($urandom_range(0, 4095));
    it.right_index  = 12'($urandom_range(0, 4095));
    it.pixel_weight = 15'($urandom_range(0, 32767));
    it.wait_drained = 1'b0;
    return it;
  endfunction

  task automatic queue_load(logic [11:0] addr, logic [15:0] sample);
    resize_item_t it;
    it = random_fields();
    it.kind = qlr_pkg::KIND_LOAD;
    it.row_address = addr;
    it.upper_sample = sample;
    if (!loaded_flag[addr]) begin
      loaded_flag[addr] = 1'b1;
      loaded_list.push_back(int'(addr));
    end
    pending_items.push_back(it);
  endtask

  task automatic queue_vertical(logic [15:0] top, logic [15:0] bottom);
    resize_item_t it;
    it = random_fields();
    it.kind = qlr_pkg::KIND_VERT;
    it.upper_sample = top;
    it.lower_sample = bottom;
    pending_items.push_back(it);
  endtask

  task automatic queue_horizontal(logic [11:0] left, logic [11:0] right, logic [14:0] w);
    resize_item_t it;
    it = random_fields();
    it.kind = qlr_pkg::KIND_HORZ;
    it.left_index = left;
    it.right_index = right;
    it.pixel_weight = w;
    pending_items.push_back(it);
  endtask

  function automatic logic [15:0] pick_sample();
    case ($urandom_range(0, 6))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  function automatic logic [14:0] pick_weight();
    case ($urandom_range(0, 9))
      0:       return 15'd0;
      1:       return qlr_pkg::Q14_ONE;
      2:       return 15'($urandom_range(16385, 32767));
      default: return 15'($urandom_range(0, 16384));
    endcase
  endfunction

  // One phase of random traffic; loads, blends of loaded taps and a few ignored items
  task automatic queue_random_phase(int count);
    resize_item_t it;
    int           sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 30 || loaded_list.size() == 0) begin
        queue_load(12'($urandom_range(0, 4095)), pick_sample());
      end else if (sel < 58) begin
        queue_vertical(pick_sample(), pick_sample());
      end else if (sel < 95) begin
        queue_horizontal(12'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]),
                         12'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]),
                         pick_weight());
      end else begin
        it = random_fields();
        it.kind = qlr_pkg::KIND_UNUSED;
        pending_items.push_back(it);
      end
      if ($urandom_range(0, 99) == 0) pending_items[$].wait_drained = 1'b1;
    end
  endtask

  // Register settings per random phase, extremes included
  logic [14:0]   phase_vweight [8];
  qlr_pkg::fmt_t phase_format  [8];

  initial begin
    resize_item_t it;
    foreach (loaded_flag[i]) loaded_flag[i] = 1'b0;

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: extremes under reset settings (weight 0, raw output)
    queue_load(12'd0, 16'd0);
    queue_load(12'd4095, 16'hFFFF);
    queue_load(12'd1, 16'hFFFF);
    queue_load(12'd2, 16'd0);
    queue_load(12'd100, 16'd12345);
    queue_load(12'd2730, 16'h5555);
    queue_vertical(16'd0, 16'hFFFF);
    queue_vertical(16'hFFFF, 16'd0);
    queue_horizontal(12'd0, 12'd4095, 15'd0);
    queue_horizontal(12'd0, 12'd4095, qlr_pkg::Q14_ONE);
    queue_horizontal(12'd4095, 12'd0, 15'd8192);
    queue_horizontal(12'd0, 12'd4095, 15'h7FFF);      // weight saturates to one
    queue_horizontal(12'd4095, 12'd0, 15'd16385);
    queue_horizontal(12'd1, 12'd2, 15'd1);            // rounding toward floor, negative step
    queue_horizontal(12'd2, 12'd1, 15'd16383);
    queue_horizontal(12'd100, 12'd2730, 15'd5461);
    it = random_fields();
    it.kind = qlr_pkg::KIND_UNUSED;                   // ignored kind, no result
    pending_items.push_back(it);
    queue_load(12'd100, 16'd7);                       // overwrite then read back
    queue_horizontal(12'd100, 12'd100, 15'd12000);
    queue_vertical(16'd32768, 16'd32767);
    wait_drained();

    phase_vweight = '{qlr_pkg::Q14_ONE, 15'd8192, 15'h7FFF, 15'd0,
                      15'($urandom_range(0, 16384)), qlr_pkg::Q14_ONE,
                      15'($urandom_range(0, 32767)), 15'd1};
    phase_format  = '{qlr_pkg::FMT_RAW, qlr_pkg::FMT_S16, qlr_pkg::FMT_U16, qlr_pkg::FMT_U8,
                      qlr_pkg::FMT_S16, qlr_pkg::FMT_U8, qlr_pkg::FMT_U16, qlr_pkg::FMT_RAW};

    for (int p = 0; p < 8; p++) begin
      cfg_write(qlr_pkg::REG_VWEIGHT, {17'd0, phase_vweight[p]});
      cfg_write(qlr_pkg::REG_FORMAT, {30'd0, phase_format[p]});
      queue_random_phase(104);
      // at least one hold-off until the pipeline is empty
      if (p == 1) pending_items[50].wait_drained = 1'b1;
      wait_drained();
    end

    repeat (10) @(posedge clk);
    if (expected_values.size() != 0) begin
      error_count++;
      $display("ERROR: %0d expected results never arrived", expected_values.size());
    end
    if (error_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  // Run limit
  initial begin
    #5_000_000;
    $display("ERROR: timeout");
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
